FILE: rtl/core/mfd_pkg.sv
// Shared types, constants and the coefficient table of the multichannel FIR decimator.
package mfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int COEF_W     = 19;
    localparam int COEF_COUNT = 63;
    localparam int MAX_CH     = 8;
    localparam int STEP_W     = 7;
    localparam int TAP_IDX_W  = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd4;

    typedef logic [TAP_IDX_W-1:0]         t_tap_idx;
    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [COEF_W-1:0]     t_coef;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } t_bk_state;

    // Symmetric low-pass kernel, oldest sample first.
    localparam t_coef COEF_TABLE [COEF_COUNT] = '{
        19'sd2158,    -19'sd3620,   -19'sd7100,   -19'sd4486,
        19'sd1833,    19'sd2758,    -19'sd2365,   -19'sd3667,
        19'sd2091,    19'sd4641,    -19'sd1618,   -19'sd5790,
        19'sd807,     19'sd7030,    19'sd412,     -19'sd8308,
        -19'sd2119,   19'sd9586,    19'sd4462,    -19'sd10802,
        -19'sd7643,   19'sd11929,   19'sd12065,   -19'sd12913,
        -19'sd18596,  19'sd13723,   19'sd29512,   -19'sd14331,
        -19'sd53266,  19'sd14702,   19'sd166092,  19'sd247319,
        19'sd166092,  19'sd14702,   -19'sd53266,  -19'sd14331,
        19'sd29512,   19'sd13723,   -19'sd18596,  -19'sd12913,
        19'sd12065,   19'sd11929,   -19'sd7643,   -19'sd10802,
        19'sd4462,    19'sd9586,    -19'sd2119,   -19'sd8308,
        19'sd412,     19'sd7030,    19'sd807,     -19'sd5790,
        -19'sd1618,   19'sd4641,    19'sd2091,    -19'sd3667,
        -19'sd2365,   19'sd2758,    19'sd1833,    -19'sd4486,
        -19'sd7100,   -19'sd3620,   19'sd2158
    };

    // Taps past the end of the table weigh nothing.
    function automatic t_coef coef_at(t_tap_idx k);
        t_coef c;
        c = '0;
        if (k < t_tap_idx'(COEF_COUNT)) begin
            c = COEF_TABLE[k[5:0]];
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/mfd_in_if.sv
// Frame channel: valid/ready handshake carrying eight channel samples.
interface mfd_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   sample_ch0;
    logic signed [15:0]   sample_ch1;
    logic signed [15:0]   sample_ch2;
    logic signed [15:0]   sample_ch3;
    logic signed [15:0]   sample_ch4;
    logic signed [15:0]   sample_ch5;
    logic signed [15:0]   sample_ch6;
    logic signed [15:0]   sample_ch7;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        input  ready
    );
    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        output ready
    );
endinterface

FILE: rtl/core/mfd_out_if.sv
// Result channel: valid/ready handshake carrying eight filtered channel values.
interface mfd_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   filtered_ch0;
    logic signed [15:0]   filtered_ch1;
    logic signed [15:0]   filtered_ch2;
    logic signed [15:0]   filtered_ch3;
    logic signed [15:0]   filtered_ch4;
    logic signed [15:0]   filtered_ch5;
    logic signed [15:0]   filtered_ch6;
    logic signed [15:0]   filtered_ch7;

    modport source (
        output valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
               filtered_ch4, filtered_ch5, filtered_ch6, filtered_ch7,
        input  ready
    );
    modport sink (
        input  valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
               filtered_ch4, filtered_ch5, filtered_ch6, filtered_ch7,
        output ready
    );
endinterface

FILE: rtl/core/mfd_front.sv
// Front end: takes frames, writes the history, counts fill and phase, queues filter jobs.
module mfd_front #(
    parameter int TAPS     = 63,
    parameter int CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mfd_in_if.sink                                i_frame,
    input  logic                                  i_cfg_valid,
    input  logic [mfd_pkg::STEP_W-1:0]            i_cfg_step,
    input  logic                                  i_back_idle,
    input  logic                                  i_queue_empty,
    output logic                                  o_wr_en,
    output logic [$clog2(TAPS)-1:0]               o_wr_addr,
    output logic [CHANNELS*mfd_pkg::SAMPLE_W-1:0] o_wr_data,
    output logic                                  o_push,
    output logic [$clog2(TAPS)-1:0]               o_push_start
);
    localparam int AW = $clog2(TAPS);
    localparam int FW = $clog2(TAPS + 1);
    localparam int SW = mfd_pkg::STEP_W;

    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [FW-1:0] r_fill, n_fill;
    logic [SW-1:0] r_phase, n_phase;
    logic [SW-1:0] r_step;
    logic [SW-1:0] step_eff;
    logic [SW:0]   phase_inc;
    logic          accept;
    logic          full_n;
    logic          emit;
    mfd_pkg::t_sample smp [mfd_pkg::MAX_CH];

    assign smp[0] = i_frame.sample_ch0;
    assign smp[1] = i_frame.sample_ch1;
    assign smp[2] = i_frame.sample_ch2;
    assign smp[3] = i_frame.sample_ch3;
    assign smp[4] = i_frame.sample_ch4;
    assign smp[5] = i_frame.sample_ch5;
    assign smp[6] = i_frame.sample_ch6;
    assign smp[7] = i_frame.sample_ch7;

    // Hold off while a filter pass is pending or running: it reads the window in place.
    assign i_frame.ready = i_back_idle && i_queue_empty;
    assign accept        = i_frame.valid && i_frame.ready;

    always_comb begin
        n_wr_pos  = (r_wr_pos == AW'(TAPS - 1)) ? '0 : r_wr_pos + 1'b1;
        n_fill    = (r_fill == FW'(TAPS)) ? r_fill : r_fill + 1'b1;
        full_n    = (n_fill == FW'(TAPS));
        step_eff  = (r_step == '0) ? SW'(1) : r_step;
        phase_inc = {1'b0, r_phase} + 1'b1;
        n_phase   = r_phase;
        if (full_n) begin
            n_phase = (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[SW-1:0];
        end
        emit = full_n && (r_phase == '0);
    end

    always_comb begin
        o_wr_data = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            o_wr_data[c*mfd_pkg::SAMPLE_W +: mfd_pkg::SAMPLE_W] = smp[c];
        end
    end

    assign o_wr_en      = accept;
    assign o_wr_addr    = r_wr_pos;
    assign o_push       = accept && emit;
    assign o_push_start = n_wr_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_fill   <= '0;
            r_phase  <= '0;
            r_step   <= mfd_pkg::STEP_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_step;
            end
            if (accept) begin
                r_wr_pos <= n_wr_pos;
                r_fill   <= n_fill;
                r_phase  <= n_phase;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_when_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (i_back_idle && i_queue_empty))
        else $error("frame taken while a filter pass was outstanding");
    a_no_job_before_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full_n) |-> !o_push)
        else $error("filter job queued before the history was full");
`endif

endmodule

FILE: rtl/core/mfd_job_fifo.sv
// Two-entry job queue between front and back end, holding window start addresses.
module mfd_job_fifo #(
    parameter int WIDTH = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2 || do_pop))
        else $error("job queue overflow");
`endif

endmodule

FILE: rtl/core/mfd_back.sv
// Back end: history memory, per-channel multiply-accumulate lanes and the result register.
module mfd_back #(
    parameter int TAPS     = 63,
    parameter int CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [$clog2(TAPS)-1:0]               i_wr_addr,
    input  logic [CHANNELS*mfd_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic                                  i_job_valid,
    input  logic [$clog2(TAPS)-1:0]               i_job_start,
    output logic                                  o_job_pop,
    output logic                                  o_idle,
    mfd_out_if.source                             o_result
);
    localparam int AW  = $clog2(TAPS);
    localparam int SMW = mfd_pkg::SAMPLE_W;
    localparam int ACW = mfd_pkg::ACC_W;
    localparam int PW  = SMW + mfd_pkg::COEF_W;

    mfd_pkg::t_bk_state r_state, n_state;

    logic [CHANNELS*SMW-1:0] r_mem [TAPS];
    logic [CHANNELS*SMW-1:0] r_rdata;
    logic [AW-1:0]           r_rd_ptr;
    logic [AW-1:0]           r_k;
    logic [AW-1:0]           r_k1;
    logic                    r_v1;
    logic                    r_v2;
    logic [ACW-1:0]          r_prod [CHANNELS];
    logic [ACW-1:0]          r_acc  [CHANNELS];
    logic                    r_out_valid;
    mfd_pkg::t_sample        r_out  [mfd_pkg::MAX_CH];
    mfd_pkg::t_coef          coef_k1;
    logic signed [PW-1:0]    prod_full [CHANNELS];
    logic                    start;
    logic                    issue;
    logic                    load_out;

    // Next state and strobes.
    always_comb begin
        n_state   = r_state;
        start     = 1'b0;
        issue     = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            mfd_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    start   = 1'b1;
                    n_state = mfd_pkg::BK_RUN;
                end
            end
            mfd_pkg::BK_RUN: begin
                issue = 1'b1;
                if (r_k == AW'(TAPS - 1)) begin
                    n_state = mfd_pkg::BK_DRAIN;
                end
            end
            mfd_pkg::BK_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = mfd_pkg::BK_DONE;
                end
            end
            mfd_pkg::BK_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    load_out = 1'b1;
                    n_state  = mfd_pkg::BK_IDLE;
                end
            end
            default: n_state = mfd_pkg::BK_IDLE;
        endcase
    end

    assign o_job_pop = start;
    assign o_idle    = (r_state == mfd_pkg::BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // History memory: one write port from the front end, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    // Walk the window oldest first.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rd_ptr <= i_job_start;
            r_k      <= '0;
        end else if (issue) begin
            r_rd_ptr <= (r_rd_ptr == AW'(TAPS - 1)) ? '0 : r_rd_ptr + 1'b1;
            r_k      <= r_k + 1'b1;
        end
        r_k1 <= r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    assign coef_k1 = mfd_pkg::coef_at(mfd_pkg::t_tap_idx'(r_k1));

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            prod_full[c] = $signed(r_rdata[c*SMW +: SMW]) * coef_k1;
        end
    end

    // Product register, then a wrapping 32-bit accumulate per lane.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_v1) begin
                r_prod[c] <= prod_full[c][ACW-1:0];
            end
            if (start) begin
                r_acc[c] <= '0;
            end else if (r_v2) begin
                r_acc[c] <= r_acc[c] + r_prod[c];
            end
        end
    end

    // Result register: free the lanes while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int c = 0; c < mfd_pkg::MAX_CH; c++) begin
                if (c < CHANNELS) begin
                    r_out[c] <= r_acc[c][ACW-1 -: SMW];
                end else begin
                    r_out[c] <= '0;
                end
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.filtered_ch0 = r_out[0];
    assign o_result.filtered_ch1 = r_out[1];
    assign o_result.filtered_ch2 = r_out[2];
    assign o_result.filtered_ch3 = r_out[3];
    assign o_result.filtered_ch4 = r_out[4];
    assign o_result.filtered_ch5 = r_out[5];
    assign o_result.filtered_ch6 = r_out[6];
    assign o_result.filtered_ch7 = r_out[7];

`ifndef SYNTHESIS
    a_mac_only_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == mfd_pkg::BK_DRAIN || r_state == mfd_pkg::BK_RUN))
        else $error("accumulate outside a filter pass");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !load_out)
        else $error("held result overwritten");
`endif

endmodule

FILE: rtl/core/multichannel_fir_decimator.sv
// Top level of the eight-channel 63-tap decimating FIR filter.
//
// Channels: i_frame takes one word of eight signed 16-bit samples per frame,
// o_result gives one word of eight signed 16-bit filter outputs (accumulator
// bits 31:16 of a wrapping 32-bit dot product per channel). i_cfg_valid with
// i_cfg_decimation_step writes the output step; o_cfg_ready is always high.
// Write it only while the block is idle; a step of zero behaves as one.
// Once TAPS frames are held, the frame that fills the history and every
// step-th frame after it start a filter pass.
// A frame that starts no pass leaves i_frame.ready high. A frame that starts
// a pass holds i_frame.ready low until that pass has loaded its result: the
// pass reads the history memory one frame per cycle through its single read
// port and feeds all lanes from that one read.
// Reset clears the fill and phase counts and sets the step to 4; the history
// needs no clearing since nothing is read before it is full.
// A stalled receiver holds the result word and frames keep flowing; the next
// pass runs to the end and holds i_frame.ready low until its result is loaded.
module multichannel_fir_decimator #(
    parameter int TAPS     = 63,
    parameter int CHANNELS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mfd_in_if.sink                     i_frame,
    mfd_out_if.source                  o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mfd_pkg::STEP_W-1:0] i_cfg_decimation_step
);
    localparam int AW = $clog2(TAPS);

    logic                                  wr_en;
    logic [AW-1:0]                         wr_addr;
    logic [CHANNELS*mfd_pkg::SAMPLE_W-1:0] wr_data;
    logic                                  push;
    logic [AW-1:0]                         push_start;
    logic                                  job_valid;
    logic [AW-1:0]                         job_start;
    logic                                  job_pop;
    logic                                  queue_empty;
    logic                                  back_idle;

    // Accept a step write at any time; the register is a plain load.
    assign o_cfg_ready = 1'b1;

    mfd_front #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (i_frame),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_step    (i_cfg_decimation_step),
        .i_back_idle   (back_idle),
        .i_queue_empty (queue_empty),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_push        (push),
        .o_push_start  (push_start)
    );

    // Queue the window start of each pass between the two halves.
    mfd_job_fifo #(
        .WIDTH (AW)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_start),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_data  (job_start),
        .o_empty (queue_empty)
    );

    mfd_back #(
        .TAPS     (TAPS),
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job_valid (job_valid),
        .i_job_start (job_start),
        .o_job_pop   (job_pop),
        .o_idle      (back_idle),
        .o_result    (o_result)
    );

endmodule
